FILE: rtl/tagged_varint_decoder_unit_macros.svh
// -----------------------------------------------------------------------------
// Tagged varint decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// -----------------------------------------------------------------------------
`ifndef TAGGED_VARINT_DECODER_UNIT_MACROS_SVH
`define TAGGED_VARINT_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tagged varint decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tagged varint decoder: next-cycle check failed");

`endif

FILE: rtl/tvd_pkg.sv
// -----------------------------------------------------------------------------
// Tagged varint decoder package
// Types, phase codes, status codes and byte constants shared by the decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvd_pkg;

  // Decoder phase codes.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SIGNED  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // Special byte values of the encoding.
  localparam logic [7:0] SIGN_BYTE  = 8'd255;
  localparam logic [7:0] LONG_TAG   = 8'd254;
  localparam logic [7:0] MAX_DIRECT = 8'd250;
  localparam logic [7:0] FIRST_TAG  = 8'd251;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORMAT    = 3'd1,
    ST_END_START = 3'd2,
    ST_END_SIGN  = 3'd3,
    ST_END_PAY   = 3'd4
  } tvd_status_e;

  typedef struct packed {
    logic [1:0]  phase;
    logic        negative;
    logic [3:0]  bytes_left;
    logic [2:0]  byte_pos;
    logic [63:0] acc;
  } tvd_state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    tvd_status_e status;
  } tvd_result_t;

  localparam tvd_state_t STATE_CLEAR = '{
    phase:      PH_IDLE,
    negative:   1'b0,
    bytes_left: 4'd0,
    byte_pos:   3'd0,
    acc:        64'd0
  };

endpackage

FILE: rtl/tvd_step.sv
// -----------------------------------------------------------------------------
// Tagged varint decoder step
// Next-state and result logic for one stream byte or end-of-stream mark.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvd_step (
  input  tvd_pkg::tvd_state_t  state_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 eos_i,
  output tvd_pkg::tvd_state_t  state_o,
  output tvd_pkg::tvd_result_t result_o
);
  import tvd_pkg::*;

  logic [1:0]  tag_off;
  logic [3:0]  tag_len;
  logic [63:0] acc_merged;
  logic [3:0]  left_dec;
  logic [63:0] small_val;

  // Tags 251..254 select payloads of 1, 2, 4 or 8 bytes.
  assign tag_off    = in_byte_i[1:0] - FIRST_TAG[1:0];
  assign tag_len    = 4'd1 << tag_off;
  assign acc_merged = state_i.acc | (64'(in_byte_i) << {state_i.byte_pos, 3'b000});
  assign left_dec   = (state_i.bytes_left != 4'd0) ? state_i.bytes_left - 4'd1 : 4'd0;
  assign small_val  = state_i.negative ? ~64'(in_byte_i) : 64'(in_byte_i);

  always_comb begin
    state_o         = state_i;
    result_o.valid  = 1'b0;
    result_o.value  = 64'd0;
    result_o.status = ST_OK;

    unique case (state_i.phase)
      PH_SIGNED, PH_PAYLOAD: begin
        if (eos_i) begin
          state_o         = STATE_CLEAR;
          result_o.valid  = 1'b1;
          result_o.status = (state_i.phase == PH_SIGNED) ? ST_END_SIGN : ST_END_PAY;
        end else if (state_i.phase == PH_PAYLOAD) begin
          if (left_dec == 4'd0) begin
            state_o        = STATE_CLEAR;
            result_o.valid = 1'b1;
            result_o.value = state_i.negative ? ~acc_merged : acc_merged;
          end else begin
            state_o.acc        = acc_merged;
            state_o.byte_pos   = state_i.byte_pos + 3'd1;
            state_o.bytes_left = left_dec;
          end
        end else if (in_byte_i == SIGN_BYTE) begin
          // A second sign byte is a format error.
          state_o         = STATE_CLEAR;
          result_o.valid  = 1'b1;
          result_o.status = ST_FORMAT;
        end else if (in_byte_i <= MAX_DIRECT) begin
          state_o        = STATE_CLEAR;
          result_o.valid = 1'b1;
          result_o.value = small_val;
        end else begin
          state_o.phase      = PH_PAYLOAD;
          state_o.bytes_left = tag_len;
          state_o.byte_pos   = 3'd0;
          state_o.acc        = 64'd0;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves the same.
        if (eos_i) begin
          state_o         = STATE_CLEAR;
          result_o.valid  = 1'b1;
          result_o.status = ST_END_START;
        end else if (in_byte_i == SIGN_BYTE) begin
          state_o          = STATE_CLEAR;
          state_o.negative = 1'b1;
          state_o.phase    = PH_SIGNED;
        end else if (in_byte_i == LONG_TAG) begin
          // The eight-byte tag is only legal after a sign byte.
          state_o         = STATE_CLEAR;
          result_o.valid  = 1'b1;
          result_o.status = ST_FORMAT;
        end else if (in_byte_i <= MAX_DIRECT) begin
          state_o        = STATE_CLEAR;
          result_o.valid = 1'b1;
          result_o.value = 64'(in_byte_i);
        end else begin
          state_o.phase      = PH_PAYLOAD;
          state_o.negative   = 1'b0;
          state_o.bytes_left = tag_len;
          state_o.byte_pos   = 3'd0;
          state_o.acc        = 64'd0;
        end
      end
    endcase
  end

endmodule

FILE: rtl/tagged_varint_decoder_unit.sv
// Path: s_axis into the input register, decoded into the result register, out on m_axis.
// Throughput: one byte or end mark per cycle while m_axis does not stall.
// The input register and the result register let both sides stall independently.
// Reset (rst_ni low, asynchronous) empties both registers and returns the decoder
// to idle with a cleared accumulator; no clearing pass is needed.
// -----------------------------------------------------------------------------
// Tagged varint decoder unit
// Decodes a byte stream of sign-prefixed, length-tagged integers into 64-bit
// signed values with a status code per result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tagged_varint_decoder_unit_macros.svh"

module tagged_varint_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value (two's complement)
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import tvd_pkg::*;

  // Input register: holds the most recently accepted transfer.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;

  // Decoder state carried from byte to byte.
  tvd_state_t  state_q;
  tvd_state_t  state_d;
  tvd_result_t step_res;

  // Result register feeding the master side.
  logic        out_valid_q;
  logic [63:0] out_value_q;
  tvd_status_e out_status_q;

  logic advance;

  // The held byte is decoded once the result register has room, either
  // because it is empty or because its transfer completes this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  tvd_step u_step (
    .state_i   (state_q),
    .in_byte_i (in_byte_q),
    .eos_i     (in_eos_q),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_res.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.valid) begin
      out_value_q  <= step_res.value;
      out_status_q <= step_res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  // Every error result carries a zero value.
  `TVD_ASSERT_NOW(a_err_zero, out_valid_q && (out_status_q != ST_OK), out_value_q == 64'd0)
  // The sign phase is only reachable with the negative flag set.
  `TVD_ASSERT_NOW(a_signed_neg, state_q.phase == PH_SIGNED, state_q.negative)
  // A payload in progress always has bytes left to collect.
  `TVD_ASSERT_NOW(a_pay_left, state_q.phase == PH_PAYLOAD, state_q.bytes_left != 4'd0)
  // Idle state holds no leftover payload.
  `TVD_ASSERT_NOW(a_idle_clear, state_q.phase == PH_IDLE,
                  (state_q.acc == 64'd0) && (state_q.bytes_left == 4'd0))
  // A decoded byte that yields a result shows it in the next cycle.
  `TVD_ASSERT_NEXT(a_res_shown, advance && step_res.valid, m_axis_tvalid)

endmodule
